### hw/rtl/hdls_pkg.sv
// Shared types and constants for the hazard DAG layer scheduler.
// Holds the command codes, the result status codes and the controller/datapath interface.
// Has no dependencies.
package hdls_pkg;

  // Default sizes of the node table, the resource table and the key.
  localparam int unsigned DEF_MAX_NODES     = 32;
  localparam int unsigned DEF_MAX_RESOURCES = 32;
  localparam int unsigned DEF_KEY_WIDTH     = 32;

  // Field widths fixed by the command and result formats.
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned NODE_W   = 5;
  localparam int unsigned LAYER_W  = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INKEY_W  = 32;
  localparam int unsigned READER_W = 32;
  // Wide enough to compare any node field against any node count.
  localparam int unsigned CMP_W    = 7;

  // Command codes.
  localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_NODE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_EDGE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WEAK_READ = 3'd4;
  localparam logic [MODE_W-1:0] MODE_WRITE     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_COMPILE   = 3'd6;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODE_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RES_FULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CYCLE      = 2'd3;

  // Datapath operations issued by the controller, one per cycle (OP_NONE while it waits).
  typedef enum logic [3:0] {
    OP_NONE,
    OP_DECODE,
    OP_EDGE_WR,
    OP_SRCH,
    OP_SCMP,
    OP_DECL_RD,
    OP_DECL_WR,
    OP_CRD,
    OP_CEV,
    OP_CLAYER,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic   capture;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              node_empty;
    logic              srch_end;
    logic              res_full;
    logic              match;
    logic              ready;
    logic              cidx_last;
    logic              new_empty;
  } dp_stat_t;

endpackage

### hw/rtl/hdls_dp.sv
// Datapath of the hazard DAG layer scheduler: command registers, node and resource
// tables, the predecessor memory, the compile sweep registers and the result register.
// Depends on hdls_pkg.
module hdls_dp #(
  parameter int unsigned MAX_NODES     = hdls_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_RESOURCES = hdls_pkg::DEF_MAX_RESOURCES,
  parameter int unsigned KEY_WIDTH     = hdls_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  hdls_pkg::dp_cmd_t                cmd,
  output hdls_pkg::dp_stat_t               stat,
  input  logic [hdls_pkg::MODE_W-1:0]      mode,
  input  logic [hdls_pkg::NODE_W-1:0]      node_a,
  input  logic [hdls_pkg::NODE_W-1:0]      node_b,
  input  logic [hdls_pkg::INKEY_W-1:0]     resource_key,
  output logic [hdls_pkg::NODE_W-1:0]      node_index,
  output logic [hdls_pkg::LAYER_W-1:0]     layer,
  output logic                             is_node_entry,
  output logic [hdls_pkg::STATUS_W-1:0]    status,
  output logic                             last
);
  import hdls_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_NODES + 1);
  localparam int unsigned AW  = $clog2(MAX_NODES);
  localparam int unsigned RCW = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned RAW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  // Resource entry: key, writer valid, last writer, reader set.
  localparam int unsigned RS_LO = 0;
  localparam int unsigned LW_LO = READER_W;
  localparam int unsigned WV_B  = READER_W + NODE_W;
  localparam int unsigned KY_LO = READER_W + NODE_W + 1;
  localparam int unsigned ENT_W = KEY_WIDTH + KY_LO;

  // Captured command.
  logic [MODE_W-1:0]    m_q;
  logic [NODE_W-1:0]    a_q;
  logic [NODE_W-1:0]    b_q;
  logic [KEY_WIDTH-1:0] key_q;

  // Table fill counts and sweep registers.
  logic [CW-1:0]        node_cnt;
  logic [RCW-1:0]       res_cnt;
  logic [RCW-1:0]       ridx;
  logic [ENT_W-1:0]     ent;
  logic [AW-1:0]        cidx;
  logic [MAX_NODES-1:0] done_m;
  logic [MAX_NODES-1:0] new_m;
  logic [LAYER_W-1:0]   lay;
  logic [STATUS_W-1:0]  res_status;
  logic [NODE_W-1:0]    res_index;

  // Predecessor rows: bit p of row c is set when node p must run before node c.
  logic [MAX_NODES-1:0] pred_mem [MAX_NODES];
  logic [MAX_NODES-1:0] pred_q;
  logic                 pred_re;
  logic [AW-1:0]        pred_raddr;
  logic                 pred_we;
  logic [AW-1:0]        pred_waddr;
  logic [MAX_NODES-1:0] pred_wdata;

  // Resource table.
  logic [ENT_W-1:0]     res_mem [MAX_RESOURCES];
  logic [ENT_W-1:0]     res_q;
  logic                 res_re;
  logic                 res_we;
  logic [ENT_W-1:0]     ent_upd;

  // Derived values.
  logic [MAX_NODES-1:0] live;
  logic                 a_ok;
  logic                 b_ok;
  logic                 edge_ok;
  logic [MAX_NODES-1:0] abit;
  logic [READER_W-1:0]  prod32;
  logic [63:0]          prod64;
  logic [MAX_NODES-1:0] prod_n;
  logic                 node_full;
  logic                 ready;
  logic                 cidx_last;

  // Node range checks and masks.
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      live[i] = (CMP_W'(i) < CMP_W'(node_cnt));
    end
    a_ok      = (CMP_W'(a_q) < CMP_W'(node_cnt));
    b_ok      = (CMP_W'(b_q) < CMP_W'(node_cnt));
    edge_ok   = a_ok && b_ok && (a_q != b_q);
    abit      = MAX_NODES'(1) << a_q;
    node_full = (node_cnt == CW'(MAX_NODES));
    ready     = !done_m[cidx] && ((pred_q & ~done_m) == '0);
    cidx_last = ((CW'(cidx) + CW'(1)) == node_cnt);
  end

  // Producers of a declaration: the last writer, and for a write every other reader.
  always_comb begin
    prod32 = '0;
    if (ent[WV_B]) begin
      prod32 = READER_W'(1) << ent[LW_LO +: NODE_W];
    end
    if (m_q == MODE_WRITE) begin
      prod32 = prod32 | ent[RS_LO +: READER_W];
    end
    prod32 = prod32 & ~(READER_W'(1) << a_q);
    prod64 = 64'(prod32);
    prod_n = prod64[MAX_NODES-1:0] & live;
  end

  // Updated resource entry after a declaration.
  always_comb begin
    ent_upd = ent;
    case (m_q)
      MODE_READ: begin
        ent_upd[RS_LO +: READER_W] = ent[RS_LO +: READER_W] | (READER_W'(1) << a_q);
      end
      MODE_WRITE: begin
        ent_upd[RS_LO +: READER_W] = '0;
        ent_upd[LW_LO +: NODE_W]   = a_q;
        ent_upd[WV_B]              = 1'b1;
      end
      default: begin
        ent_upd = ent;
      end
    endcase
  end

  // Memory port control.
  always_comb begin
    pred_re    = 1'b0;
    pred_raddr = cidx;
    pred_we    = 1'b0;
    pred_waddr = AW'(b_q);
    pred_wdata = pred_q | abit;
    res_re     = 1'b0;
    res_we     = 1'b0;
    unique case (cmd.op)
      OP_DECODE: begin
        pred_re    = (m_q == MODE_ADD_EDGE);
        pred_raddr = AW'(b_q);
        pred_we    = (m_q == MODE_ADD_NODE) && !node_full;
        pred_waddr = AW'(node_cnt);
        pred_wdata = '0;
      end
      OP_EDGE_WR: begin
        pred_we = edge_ok;
      end
      OP_SRCH: begin
        res_re = (ridx != res_cnt);
      end
      OP_DECL_RD: begin
        pred_re    = 1'b1;
        pred_raddr = AW'(a_q);
      end
      OP_DECL_WR: begin
        pred_we    = a_ok;
        pred_waddr = AW'(a_q);
        pred_wdata = pred_q | prod_n;
        res_we     = 1'b1;
      end
      OP_CRD: begin
        pred_re = 1'b1;
      end
      default: begin
        pred_re = 1'b0;
      end
    endcase
  end

  // Predecessor memory.
  always_ff @(posedge clk) begin
    if (pred_we) begin
      pred_mem[pred_waddr] <= pred_wdata;
    end
    if (pred_re) begin
      pred_q <= pred_mem[pred_raddr];
    end
  end

  // Resource memory.
  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[ridx[RAW-1:0]] <= ent_upd;
    end
    if (res_re) begin
      res_q <= res_mem[ridx[RAW-1:0]];
    end
  end

  // Status back to the controller.
  always_comb begin
    stat.mode       = m_q;
    stat.node_empty = (node_cnt == '0);
    stat.srch_end   = (ridx == res_cnt);
    stat.res_full   = (res_cnt == RCW'(MAX_RESOURCES));
    stat.match      = (res_q[KY_LO +: KEY_WIDTH] == key_q);
    stat.ready      = ready;
    stat.cidx_last  = cidx_last;
    stat.new_empty  = (new_m == '0);
  end

  // Table counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_cnt <= '0;
      res_cnt  <= '0;
    end else begin
      if (cmd.op == OP_DECODE && m_q == MODE_CLEAR) begin
        node_cnt <= '0;
        res_cnt  <= '0;
      end
      if (cmd.op == OP_DECODE && m_q == MODE_ADD_NODE && !node_full) begin
        node_cnt <= node_cnt + CW'(1);
      end
      if (cmd.op == OP_SRCH && ridx == res_cnt && res_cnt != RCW'(MAX_RESOURCES)) begin
        res_cnt <= res_cnt + RCW'(1);
      end
    end
  end

  // Command capture, sweeps and the result register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      m_q   <= mode;
      a_q   <= node_a;
      b_q   <= node_b;
      key_q <= KEY_WIDTH'(resource_key);
    end
    case (cmd.op)
      OP_DECODE: begin
        res_status <= ST_OK;
        res_index  <= '0;
        unique case (m_q)
          MODE_ADD_NODE: begin
            if (node_full) begin
              res_status <= ST_NODE_FULL;
            end else begin
              res_index <= NODE_W'(node_cnt);
            end
          end
          MODE_READ, MODE_WEAK_READ, MODE_WRITE: begin
            ridx <= '0;
          end
          MODE_COMPILE: begin
            done_m <= '0;
            new_m  <= '0;
            lay    <= '0;
            cidx   <= '0;
          end
          default: begin
            res_index <= '0;
          end
        endcase
      end
      OP_SRCH: begin
        if (ridx == res_cnt) begin
          if (res_cnt == RCW'(MAX_RESOURCES)) begin
            res_status <= ST_RES_FULL;
          end else begin
            ent <= {key_q, 1'b0, NODE_W'(0), READER_W'(0)};
          end
        end
      end
      OP_SCMP: begin
        if (res_q[KY_LO +: KEY_WIDTH] == key_q) begin
          ent <= res_q;
        end else begin
          ridx <= ridx + RCW'(1);
        end
      end
      OP_CEV: begin
        if (ready) begin
          node_index    <= NODE_W'(cidx);
          layer         <= lay;
          is_node_entry <= 1'b1;
          status        <= ST_OK;
          last          <= 1'b0;
          new_m[cidx]   <= 1'b1;
        end
        if (!cidx_last) begin
          cidx <= cidx + AW'(1);
        end
      end
      OP_CLAYER: begin
        if (new_m == '0) begin
          res_status <= (done_m == live) ? ST_OK : ST_CYCLE;
        end else begin
          done_m <= done_m | new_m;
          new_m  <= '0;
          lay    <= lay + LAYER_W'(1);
          cidx   <= '0;
        end
      end
      OP_FINISH: begin
        node_index    <= res_index;
        layer         <= '0;
        is_node_entry <= 1'b0;
        status        <= res_status;
        last          <= 1'b1;
      end
      default: begin
        lay <= lay;
      end
    endcase
  end

endmodule

### hw/rtl/hdls_ctrl.sv
// Controller of the hazard DAG layer scheduler: sequences each command through the
// datapath and owns both channel handshakes.
// Depends on hdls_pkg.
module hdls_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  hdls_pkg::dp_stat_t stat,
  output hdls_pkg::dp_cmd_t  cmd
);
  import hdls_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_EDGE_WR,
    S_SRCH,
    S_SCMP,
    S_DECL_RD,
    S_DECL_WR,
    S_CRD,
    S_CEV,
    S_CLAYER,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   load;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign load     = (cmd.op == OP_FINISH) || (cmd.op == OP_CEV && stat.ready);

  // Next state and datapath operation.
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.op      = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        unique case (stat.mode) inside
          MODE_ADD_EDGE:                         state_next = S_EDGE_WR;
          MODE_READ, MODE_WEAK_READ, MODE_WRITE: state_next = S_SRCH;
          MODE_COMPILE: state_next = stat.node_empty ? S_FINISH : S_CRD;
          default:                               state_next = S_FINISH;
        endcase
      end
      S_EDGE_WR: begin
        cmd.op     = OP_EDGE_WR;
        state_next = S_FINISH;
      end
      S_SRCH: begin
        cmd.op = OP_SRCH;
        if (!stat.srch_end) begin
          state_next = S_SCMP;
        end else if (stat.res_full) begin
          state_next = S_FINISH;
        end else begin
          state_next = S_DECL_RD;
        end
      end
      S_SCMP: begin
        cmd.op     = OP_SCMP;
        state_next = stat.match ? S_DECL_RD : S_SRCH;
      end
      S_DECL_RD: begin
        cmd.op     = OP_DECL_RD;
        state_next = S_DECL_WR;
      end
      S_DECL_WR: begin
        cmd.op     = OP_DECL_WR;
        state_next = S_FINISH;
      end
      S_CRD: begin
        cmd.op     = OP_CRD;
        state_next = S_CEV;
      end
      S_CEV: begin
        // A ready node waits here until the result register is free.
        if (!stat.ready || out_free) begin
          cmd.op     = OP_CEV;
          state_next = stat.cidx_last ? S_CLAYER : S_CRD;
        end
      end
      S_CLAYER: begin
        cmd.op     = OP_CLAYER;
        state_next = stat.new_empty ? S_FINISH : S_CRD;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/hazard_dag_layer_scheduler.sv
// Top level of the hazard DAG layer scheduler.
// Instantiates the controller (hdls_ctrl) and the datapath (hdls_dp); depends on hdls_pkg.
//
// Usage: commands enter on the in channel (in_valid / in_stall with mode, node_a,
// node_b, resource_key); results leave on the out channel (out_valid / out_stall with
// node_index, layer, is_node_entry, status, last). Every command except compile gives
// one result with last set. Compile gives one transaction per scheduled node, in layer
// order and ascending index within a layer, then a status transaction with last set.
// One command is worked on at a time; in_stall is high until its final result has
// been loaded into the output register, so the next command is taken while that
// result still waits to be accepted.
// Clear, add node and unknown codes run decode and finish; add edge adds an edge write
// step. A declaration compares the keys one entry at a time (single-port key table), then
// reads and writes back the entry, found or new, or finishes when the table is full.
// Compile checks each node's predecessor row in turn, closes each layer and stops after
// a sweep with no new node; the predecessor memory gives one row per read.
// Reset clears the state machine, the result valid and both table counts; no memory
// clearing pass is needed. When the receiver stalls, the held result stays stable and
// the compile sweep pauses at the next node to be emitted.
module hazard_dag_layer_scheduler #(
  parameter int unsigned MAX_NODES     = hdls_pkg::DEF_MAX_NODES,
  parameter int unsigned MAX_RESOURCES = hdls_pkg::DEF_MAX_RESOURCES,
  parameter int unsigned KEY_WIDTH     = hdls_pkg::DEF_KEY_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hdls_pkg::MODE_W-1:0]   mode,
  input  logic [hdls_pkg::NODE_W-1:0]   node_a,
  input  logic [hdls_pkg::NODE_W-1:0]   node_b,
  input  logic [hdls_pkg::INKEY_W-1:0]  resource_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hdls_pkg::NODE_W-1:0]   node_index,
  output logic [hdls_pkg::LAYER_W-1:0]  layer,
  output logic                          is_node_entry,
  output logic [hdls_pkg::STATUS_W-1:0] status,
  output logic                          last
);
  import hdls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Command sequencer.
  hdls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Tables, memories and result register.
  hdls_dp #(
    .MAX_NODES     (MAX_NODES),
    .MAX_RESOURCES (MAX_RESOURCES),
    .KEY_WIDTH     (KEY_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .node_a        (node_a),
    .node_b        (node_b),
    .resource_key  (resource_key),
    .node_index    (node_index),
    .layer         (layer),
    .is_node_entry (is_node_entry),
    .status        (status),
    .last          (last)
  );

endmodule
